>>> sv/oate_pkg.sv
// Shared types and constants for the ordered array table engine.
package oate_pkg;

  localparam int DataW  = 32;  // entry width
  localparam int PosW   = 8;   // width of position and found_position ports
  localparam int CountW = 9;   // width of the count_after port

  typedef enum logic [2:0] {
    FN_PUSH   = 3'd0,
    FN_INSERT = 3'd1,
    FN_POP    = 3'd2,
    FN_DELETE = 3'd3,
    FN_REMOVE = 3'd4,
    FN_FIND   = 3'd5,
    FN_READ   = 3'd6,
    FN_WRITE  = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_FULL  = 3'd2,
    ST_EMPTY = 3'd3,
    ST_MISS  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_PUT,
    S_READ,
    S_RESP
  } state_t;

endpackage

>>> sv/ordered_array_table_engine.sv
// Top level of the ordered array table engine: sequencer, count and result registers.
//
//   channel | signals                                              | direction
//   --------+------------------------------------------------------+----------
//   request | in_valid, in_ready, func, position, operand_value    | in
//   result  | out_valid, out_ready, status, read_value,            | out
//           | found_position, count_after, is_empty_flag           |
//
// Push, pop, write and any rejected request go straight to the result state;
// read passes through a storage read state. Insert, delete, remove-all and
// find walk the entries one entry per cycle through the single storage read
// port, with the shift or compacting write in the cycle after the read.
// Reset clears the count and the sequencer; the entry storage is not cleared.
// in_ready is high only in idle. A finished result waits in a holding register
// and a new request is accepted while the output register is still unread.
module ordered_array_table_engine #(
  parameter int CAPACITY = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        func,
  input  logic [oate_pkg::PosW-1:0]         position,
  input  logic signed [oate_pkg::DataW-1:0] operand_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        status,
  output logic signed [oate_pkg::DataW-1:0] read_value,
  output logic [oate_pkg::PosW-1:0]         found_position,
  output logic [oate_pkg::CountW-1:0]       count_after,
  output logic                              is_empty_flag
);

  import oate_pkg::*;

  localparam int AW = $clog2(CAPACITY);        // entry index width
  localparam int CW = $clog2(CAPACITY + 1);    // count width, holds CAPACITY
  localparam int XW = (CW > PosW) ? CW : PosW; // width for index vs count checks

  // sequencer and request registers
  state_t               state, state_next;
  func_t                op, op_next;
  logic [AW-1:0]        pos, pos_next;
  logic signed [DataW-1:0] val, val_next;
  logic [CW-1:0]        count, count_next;

  // walk pointers: read pointer, index of the entry in the read register, write count
  logic [AW-1:0]        rptr, rptr_next;
  logic                 pend, pend_next;
  logic [AW-1:0]        pidx, pidx_next;
  logic [CW-1:0]        wcnt, wcnt_next;

  // result waiting for the output register
  status_t              res_status, res_status_next;
  logic signed [DataW-1:0] res_rd, res_rd_next;
  logic [AW-1:0]        res_fpos, res_fpos_next;

  // output register
  status_t              out_status;
  logic signed [DataW-1:0] out_rd;
  logic [AW-1:0]        out_fpos;
  logic [CW-1:0]        out_count;

  // storage port
  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [DataW-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic signed [DataW-1:0] rdata;

  logic                 accept;
  logic                 load_out;
  logic [XW-1:0]        pos_x, cnt_x;
  logic                 is_full, tbl_empty;
  logic                 hit;
  logic                 last;

  oate_store #(
    .DEPTH (CAPACITY),
    .DW    (DataW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state == S_RESP) && (!out_valid || out_ready);

  assign pos_x     = XW'(position);
  assign cnt_x     = XW'(count);
  assign is_full   = (count == CW'(CAPACITY));
  assign tbl_empty = (count == '0);

  // shared compare on the entry just read
  assign hit  = (rdata == val);
  // end of walk: insert walks down to the index, the rest up to the last entry
  assign last = (op == FN_INSERT) ? (rptr == pos) : (rptr == AW'(count - CW'(1)));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_RESP;
          unique case (func_t'(func))
            FN_INSERT: begin
              if (pos_x < cnt_x && !is_full) begin
                state_next = S_SCAN;
              end
            end
            FN_DELETE: begin
              if (pos_x + XW'(1) < cnt_x) begin
                state_next = S_SCAN;
              end
            end
            FN_REMOVE, FN_FIND: begin
              if (!tbl_empty) begin
                state_next = S_SCAN;
              end
            end
            FN_READ: begin
              if (pos_x < cnt_x) begin
                state_next = S_READ;
              end
            end
            default: state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (op == FN_FIND && pend && hit) begin
          state_next = S_RESP;
        end else if (last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: state_next = (op == FN_INSERT) ? S_PUT : S_RESP;
      S_PUT:  state_next = S_RESP;
      S_READ: state_next = S_RESP;
      S_RESP: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    op_next         = op;
    pos_next        = pos;
    val_next        = val;
    count_next      = count;
    rptr_next       = rptr;
    pend_next       = pend;
    pidx_next       = pidx;
    wcnt_next       = wcnt;
    res_status_next = res_status;
    res_rd_next     = res_rd;
    res_fpos_next   = res_fpos;
    we              = 1'b0;
    waddr           = pidx;
    wdata           = rdata;
    raddr           = rptr;

    unique case (state)
      S_IDLE: begin
        raddr = AW'(position);
        if (accept) begin
          op_next         = func_t'(func);
          pos_next        = AW'(position);
          val_next        = operand_value;
          pend_next       = 1'b0;
          wcnt_next       = '0;
          res_status_next = ST_OK;
          res_rd_next     = '0;
          res_fpos_next   = '0;
          unique case (func_t'(func))
            FN_PUSH: begin
              if (is_full) begin
                res_status_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = AW'(count);
                wdata      = operand_value;
                count_next = count + CW'(1);
              end
            end
            FN_INSERT: begin
              if (pos_x > cnt_x) begin
                res_status_next = ST_RANGE;
              end else if (is_full) begin
                res_status_next = ST_FULL;
              end else if (pos_x == cnt_x) begin
                we         = 1'b1;
                waddr      = AW'(position);
                wdata      = operand_value;
                count_next = count + CW'(1);
              end else begin
                rptr_next = AW'(count - CW'(1));
              end
            end
            FN_POP: begin
              if (tbl_empty) begin
                res_status_next = ST_EMPTY;
              end else begin
                count_next = count - CW'(1);
              end
            end
            FN_DELETE: begin
              if (pos_x >= cnt_x) begin
                res_status_next = ST_RANGE;
              end else if (pos_x + XW'(1) == cnt_x) begin
                count_next = count - CW'(1);
              end else begin
                rptr_next = AW'(position) + AW'(1);
              end
            end
            FN_REMOVE: begin
              rptr_next = '0;
            end
            FN_FIND: begin
              res_status_next = ST_MISS;
              rptr_next       = '0;
            end
            FN_READ: begin
              if (pos_x >= cnt_x) begin
                res_status_next = ST_RANGE;
              end
            end
            FN_WRITE: begin
              if (pos_x >= cnt_x) begin
                res_status_next = ST_RANGE;
              end else begin
                we    = 1'b1;
                waddr = AW'(position);
                wdata = operand_value;
              end
            end
            default: res_status_next = ST_OK;
          endcase
        end
      end
      S_SCAN, S_TAIL: begin
        // finish the entry read last cycle
        if (pend) begin
          case (op)
            FN_INSERT: begin
              we    = 1'b1;
              waddr = pidx + AW'(1);
            end
            FN_DELETE: begin
              we    = 1'b1;
              waddr = pidx - AW'(1);
            end
            FN_REMOVE: begin
              if (!hit) begin
                we        = 1'b1;
                waddr     = AW'(wcnt);
                wcnt_next = wcnt + CW'(1);
              end
            end
            FN_FIND: begin
              if (hit) begin
                res_status_next = ST_OK;
                res_fpos_next   = pidx;
              end
            end
            default: we = 1'b0;
          endcase
        end
        if (state == S_SCAN) begin
          pend_next = 1'b1;
          pidx_next = rptr;
          rptr_next = (op == FN_INSERT) ? rptr - AW'(1) : rptr + AW'(1);
        end else begin
          pend_next = 1'b0;
          if (op == FN_DELETE) begin
            count_next = count - CW'(1);
          end else if (op == FN_REMOVE) begin
            count_next = wcnt_next;
          end
        end
      end
      S_PUT: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = val;
        count_next = count + CW'(1);
      end
      S_READ: begin
        res_rd_next = rdata;
      end
      S_RESP: begin
        pend_next = 1'b0;
      end
      default: pend_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    pos        <= pos_next;
    val        <= val_next;
    rptr       <= rptr_next;
    pidx       <= pidx_next;
    wcnt       <= wcnt_next;
    res_status <= res_status_next;
    res_rd     <= res_rd_next;
    res_fpos   <= res_fpos_next;
    if (load_out) begin
      out_status <= res_status;
      out_rd     <= res_rd;
      out_fpos   <= res_fpos;
      out_count  <= count;
    end
  end

  assign status         = out_status;
  assign read_value     = out_rd;
  assign found_position = PosW'(out_fpos);
  assign count_after    = CountW'(out_count);
  assign is_empty_flag  = (out_count == '0);

endmodule

>>> sv/oate_store.sv
// Entry storage: one write port, one read port with registered read data.
module oate_store #(
  parameter int DEPTH = 256,
  parameter int DW    = 32
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic signed [DW-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic signed [DW-1:0]         rdata
);

  logic signed [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
